// ===== sv/dlta_pkg.sv =====
// shared types and constants for the lease table allocator
// token format passed along the cell chain, reply and message codes
package dlta_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int MAC_BYTES     = 6;
    localparam int MAC_W         = 48;
    localparam int IP_W          = 32;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_IP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 1'd1;

    localparam logic [IP_W-1:0] SERVER_IP_RST = 32'h0000_0000;
    localparam logic [IP_W-1:0] MASK_RST      = 32'hFFFF_FF00;

    localparam logic [1:0] MSG_DISCOVER = 2'd0;
    localparam logic [1:0] MSG_REQUEST  = 2'd1;

    localparam logic [1:0] KIND_DROP  = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_NAK   = 2'd3;

    // only the first MAC_BYTES bytes take part, the first byte being the top one
    function automatic logic [MAC_W-1:0] f_mac_mask();
        logic [MAC_W-1:0] m;
        m = '1;
        if (MAC_BYTES < 6) begin
            m = m << (8 * (6 - MAC_BYTES));
        end
        return m;
    endfunction

    localparam logic [MAC_W-1:0] MAC_MASK = f_mac_mask();

    typedef enum logic {
        TOK_SCAN,
        TOK_CLAIM
    } t_tok_op;

    typedef struct packed {
        logic            valid;
        t_tok_op         op;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
        logic            hit;
        logic            free_seen;
        logic            pending;
    } t_tok;

endpackage

// ===== sv/dlta_cell.sv =====
// one lease table entry: used flag, mac and ip, plus a token register
// scan tokens look for a mac match, claim tokens fill the first free entry; uses dlta_pkg
module dlta_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dlta_pkg::t_tok i_tok,
    output dlta_pkg::t_tok o_tok
);
    import dlta_pkg::*;

    logic             r_used;
    logic [MAC_W-1:0] r_mac;
    logic [IP_W-1:0]  r_ip;
    t_tok             r_tok;
    t_tok             n_tok;
    logic             w_claim;

    assign w_claim = i_tok.valid && (i_tok.op == TOK_CLAIM) && i_tok.pending && !r_used;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            case (i_tok.op)
                TOK_SCAN: begin
                    if (r_used) begin
                        if (!i_tok.hit && (r_mac == i_tok.mac)) begin
                            n_tok.hit = 1'b1;
                            n_tok.ip  = r_ip;
                        end
                    end else begin
                        n_tok.free_seen = 1'b1;
                    end
                end
                TOK_CLAIM: begin
                    if (w_claim) begin
                        n_tok.pending = 1'b0;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_claim) begin
                r_used <= 1'b1;
            end
        end
        if (w_claim) begin
            r_mac <= i_tok.mac;
            r_ip  <= i_tok.ip;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== sv/dhcp_lease_table_allocator.sv =====
// an accepted word sends a scan token down the cell chain; a hit, or a full table or pool,
// ends the message there, and a miss with a free entry sends a claim token after it to fill
// the entry; a bad header or message type is dropped at once. one message at a time: no new
// word is taken until the result has gone to the output register, which waits on i_m_tready
// reset (synchronous, active low) frees all entries, sets the offset to 1 and
// loads the register defaults; no clearing pass is needed
module dhcp_lease_table_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dlta_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dlta_pkg::IP_W-1:0]        i_cfg_data,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // client_mac [47:0], requested_ip [79:48]
    input  logic [79:0]                      i_s_tdata,
    // header_valid [0], req_type [2:1], has_requested_ip [3]
    input  logic [3:0]                       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // your_ip [31:0]
    output logic [31:0]                      o_m_tdata,
    // reply_kind [1:0]
    output logic [1:0]                       o_m_tuser
);
    import dlta_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CLAIM,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [IP_W-1:0] r_server_ip;
    logic [IP_W-1:0] r_mask;
    logic [IP_W-1:0] r_next_off;
    logic [1:0]      r_type;
    logic            r_has_req;
    logic [IP_W-1:0] r_req_ip;
    logic [1:0]      r_res_kind;
    logic [IP_W-1:0] r_res_ip;
    logic            r_m_valid;
    logic [1:0]      r_m_kind;
    logic [IP_W-1:0] r_m_ip;
    t_tok            r_inj;

    t_tok            w_tok [TABLE_ENTRIES+1];
    t_tok            w_last;
    logic [IP_W-1:0] w_addr;
    logic [IP_W-1:0] w_lease;
    logic            w_s_acc;
    logic            w_take;
    logic            w_hv;
    logic [1:0]      w_type;

    assign w_tok[0] = r_inj;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        dlta_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_last  = w_tok[TABLE_ENTRIES];
    assign w_addr  = (r_server_ip & ~r_mask) + r_next_off;
    assign w_lease = w_addr | (r_mask & r_server_ip);
    assign w_s_acc = i_s_tvalid && o_s_tready;
    assign w_take  = !r_m_valid || i_m_tready;
    assign w_hv    = i_s_tuser[0];
    assign w_type  = i_s_tuser[2:1];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_ip;
    assign o_m_tuser   = r_m_kind;

    function automatic logic [1:0] f_kind(input logic [1:0] typ, input logic has_req,
                                          input logic [IP_W-1:0] req_ip,
                                          input logic [IP_W-1:0] ip);
        logic [1:0] k;
        k = KIND_ACK;
        if (typ == MSG_DISCOVER) begin
            k = KIND_OFFER;
        end else if (has_req && (req_ip != ip)) begin
            k = KIND_NAK;
        end
        return k;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_server_ip <= SERVER_IP_RST;
            r_mask      <= MASK_RST;
            r_next_off  <= 32'd1;
            r_m_valid   <= 1'b0;
            r_inj.valid <= 1'b0;
        end else begin
            r_inj.valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SERVER_IP:   r_server_ip <= i_cfg_data;
                    CFG_SUBNET_MASK: r_mask      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_type    <= w_type;
                        r_has_req <= i_s_tuser[3];
                        r_req_ip  <= i_s_tdata[79:48];
                        if (w_hv && (w_type == MSG_DISCOVER || w_type == MSG_REQUEST)) begin
                            r_inj.valid     <= 1'b1;
                            r_inj.op        <= TOK_SCAN;
                            r_inj.mac       <= i_s_tdata[47:0] & MAC_MASK;
                            r_inj.ip        <= '0;
                            r_inj.hit       <= 1'b0;
                            r_inj.free_seen <= 1'b0;
                            r_inj.pending   <= 1'b0;
                            r_state         <= S_SCAN;
                        end else begin
                            r_res_kind <= KIND_DROP;
                            r_res_ip   <= '0;
                            r_state    <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_last.valid) begin
                        if (w_last.hit) begin
                            r_res_kind <= f_kind(r_type, r_has_req, r_req_ip, w_last.ip);
                            r_res_ip   <= w_last.ip;
                            r_state    <= S_OUT;
                        end else if (!w_last.free_seen || ((w_addr & r_mask) != '0)) begin
                            // table full or pool exhausted
                            r_res_kind <= KIND_DROP;
                            r_res_ip   <= '0;
                            r_state    <= S_OUT;
                        end else begin
                            r_res_kind    <= f_kind(r_type, r_has_req, r_req_ip, w_lease);
                            r_res_ip      <= w_lease;
                            r_next_off    <= r_next_off + 32'd1;
                            r_inj.valid   <= 1'b1;
                            r_inj.op      <= TOK_CLAIM;
                            r_inj.mac     <= w_last.mac;
                            r_inj.ip      <= w_lease;
                            r_inj.hit     <= 1'b0;
                            r_inj.free_seen <= 1'b0;
                            r_inj.pending <= 1'b1;
                            r_state       <= S_CLAIM;
                        end
                    end
                end
                S_CLAIM: begin
                    if (w_last.valid) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_take) begin
                        r_m_valid <= 1'b1;
                        r_m_kind  <= r_res_kind;
                        r_m_ip    <= r_res_ip;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_drop_zero_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_kind == KIND_DROP) |-> (r_m_ip == '0))
        else $error("dropped word carries a nonzero address");

    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_last.valid && !w_last.hit && w_last.free_seen
         && ((w_addr & r_mask) == '0)) |=> (r_next_off == $past(r_next_off) + 32'd1))
        else $error("offset did not advance on allocation");

    a_claim_in_claim_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last.valid && w_last.op == TOK_CLAIM) |-> (r_state == S_CLAIM))
        else $error("claim token left the chain outside the claim phase");

    a_claim_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last.valid && w_last.op == TOK_CLAIM) |-> !w_last.pending)
        else $error("claim token found no free entry");
`endif

endmodule

// ===== sim/dhcp_lease_table_allocator_tb.sv =====
// self-checking testbench for the dhcp lease table allocator
// drives client messages and register writes with random idling and checks
// every reply; depends on dlta_pkg and dhcp_lease_table_allocator
module dhcp_lease_table_allocator_tb;
    import dlta_pkg::*;

    localparam int CYCLE_LIMIT  = 600_000;
    localparam int DRAIN_CYCLES = 2 * TABLE_ENTRIES + 8;
    localparam int PHASE_ITEMS  = 305;

    typedef struct packed {
        logic             hdr_ok;
        logic [1:0]       msg_type;
        logic [MAC_W-1:0] mac;
        logic             has_req;
        logic [IP_W-1:0]  req_ip;
    } t_msg;

    typedef struct packed {
        logic [1:0]      kind;
        logic [IP_W-1:0] ip;
    } t_reply;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SERVER_IP;
    logic [IP_W-1:0]      cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic [79:0]          s_data    = '0;
    logic [3:0]           s_user    = '0;
    logic                 m_ready   = 1'b0;

    logic                 o_cfg_ready;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [31:0]          o_m_tdata;
    logic [1:0]           o_m_tuser;

    // predictor copy of the lease table and registers
    logic                 lease_used [TABLE_ENTRIES];
    logic [MAC_W-1:0]     lease_mac  [TABLE_ENTRIES];
    logic [IP_W-1:0]      lease_ip   [TABLE_ENTRIES];
    logic [IP_W-1:0]      lease_offset;
    logic [IP_W-1:0]      srv_ip;
    logic [IP_W-1:0]      net_mask;

    t_reply               pending_replies[$];
    t_reply               exp_r;
    bit                   snd_no_idle = 1'b0;
    bit                   rcv_no_idle = 1'b0;
    int                   mismatch_cnt = 0;
    int                   msg_cnt = 0;
    int                   reply_cnt = 0;
    int                   cfg_writes = 0;
    int                   kind_seen [4];
    int                   cycle_cnt = 0;

    dhcp_lease_table_allocator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),   // client_mac [47:0], requested_ip [79:48]
        .i_s_tuser   (s_user),   // header_valid [0], req_type [2:1], has_requested_ip [3]
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata), // your_ip [31:0]
        .o_m_tuser   (o_m_tuser)  // reply_kind [1:0]
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_cnt, pending_replies.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("mismatch in %s: expected %h, got %h (cycle %0d)", what, want, got, cycle_cnt);
        mismatch_cnt++;
    endtask

    // table lookup, allocation on a miss, and reply selection
    function automatic t_reply lease_predict(input t_msg m);
        t_reply           r;
        int               slot;
        int               free_slot;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  addr;
        r.kind    = KIND_DROP;
        r.ip      = '0;
        slot      = -1;
        free_slot = -1;
        mac       = m.mac & MAC_MASK;
        if (m.hdr_ok && (m.msg_type == MSG_DISCOVER || m.msg_type == MSG_REQUEST)) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (lease_used[i]) begin
                    if (slot < 0 && lease_mac[i] == mac) slot = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (slot < 0 && free_slot >= 0) begin
                addr = (srv_ip & ~net_mask) + lease_offset;
                // sum spilling into network bits means the pool is used up
                if ((addr & net_mask) == '0) begin
                    lease_offset          = lease_offset + 32'd1;
                    lease_used[free_slot] = 1'b1;
                    lease_mac[free_slot]  = mac;
                    lease_ip[free_slot]   = addr | (net_mask & srv_ip);
                    slot                  = free_slot;
                end
            end
            if (slot >= 0) begin
                r.ip = lease_ip[slot];
                if (m.msg_type == MSG_DISCOVER) r.kind = KIND_OFFER;
                else if (m.has_req && m.req_ip != r.ip) r.kind = KIND_NAK;
                else r.kind = KIND_ACK;
            end
        end
        return r;
    endfunction

    function automatic t_msg mk_msg(input logic hdr_ok, input logic [1:0] msg_type,
                                    input logic [MAC_W-1:0] mac, input logic has_req,
                                    input logic [IP_W-1:0] req_ip);
        t_msg m;
        m.hdr_ok   = hdr_ok;
        m.msg_type = msg_type;
        m.mac      = mac;
        m.has_req  = has_req;
        m.req_ip   = req_ip;
        return m;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    task automatic send_msg(input t_msg m);
        int gap;
        gap = snd_no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {m.req_ip, m.mac};
        s_user  <= {m.has_req, m.msg_type, m.hdr_ok};
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
        pending_replies.push_back(lease_predict(m));
        msg_cnt++;
    endtask

    // sender goes quiet until every reply is in, then the block settles
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [IP_W-1:0] server, input logic [IP_W-1:0] mask);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SERVER_IP;
        cfg_data  <= server;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        srv_ip = server;
        cfg_index <= CFG_SUBNET_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        net_mask = mask;
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic test_header_and_type();
        send_msg(mk_msg(1'b0, MSG_DISCOVER, '0, 1'b0, '0));
        send_msg(mk_msg(1'b1, 2'd2, '1, 1'b1, '1));
        send_msg(mk_msg(1'b1, 2'd3, 48'hA5A5_5A5A_0F0F, 1'b0, 32'h1234_5678));
    endtask

    // default registers: first leases come from host part zero plus the offset
    task automatic test_lease_basic();
        send_msg(mk_msg(1'b1, MSG_DISCOVER, '0, 1'b0, '0));
        send_msg(mk_msg(1'b1, MSG_REQUEST, '0, 1'b0, '1));
        send_msg(mk_msg(1'b1, MSG_REQUEST, '0, 1'b1, 32'd1));
        send_msg(mk_msg(1'b1, MSG_REQUEST, '0, 1'b1, 32'd2));
        // request from an unknown mac allocates and then naks
        send_msg(mk_msg(1'b1, MSG_REQUEST, '1, 1'b1, '0));
        send_msg(mk_msg(1'b1, MSG_DISCOVER, '1, 1'b0, '0));
        send_msg(mk_msg(1'b0, MSG_REQUEST, '1, 1'b1, 32'd2));
    endtask

    task automatic test_pool_exhausted();
        write_regs('1, 32'hFFFF_FFFE);
        send_msg(mk_msg(1'b1, MSG_DISCOVER, 48'h0123_4567_89AB, 1'b0, '0));
        // known mac keeps its stored lease
        send_msg(mk_msg(1'b1, MSG_REQUEST, '0, 1'b1, 32'd1));
        write_regs('0, '1);
        send_msg(mk_msg(1'b1, MSG_DISCOVER, 48'h0123_4567_89AB, 1'b0, '0));
        // empty mask: host part wraps past zero
        write_regs('1, '0);
        send_msg(mk_msg(1'b1, MSG_REQUEST, 48'h0123_4567_89AB, 1'b1, 32'd2));
        send_msg(mk_msg(1'b1, MSG_DISCOVER, 48'h8000_0000_0001, 1'b1, '1));
    endtask

    task automatic test_random_phases();
        logic [IP_W-1:0]  server;
        logic [IP_W-1:0]  mask;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  req_ip;
        logic [1:0]       msg_type;
        int               len;
        int               sel;
        int               leased[$];
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    server = {24'($urandom_range(0, 32'hFF_FFFF)),
                              8'($urandom_range(0, 250))};
                    mask   = 32'hFFFF_FF00;
                end
                1: begin
                    server = '0;
                    mask   = '1;
                end
                2: begin
                    server = '1;
                    mask   = '0;
                end
                default: begin
                    server = $urandom;
                    len    = $urandom_range(0, 32);
                    if ($urandom_range(0, 3) == 0) mask = $urandom;
                    else mask = (len == 0) ? '0 : ~32'h0 << (32 - len);
                end
            endcase
            write_regs(server, mask);
            snd_no_idle = (p == 3);
            rcv_no_idle = (p == 3 || p == 4);
            repeat (PHASE_ITEMS) begin
                leased.delete();
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (lease_used[i]) leased.push_back(i);
                end
                sel    = $urandom_range(0, 19);
                mac    = rand_mac();
                req_ip = $urandom;
                // mostly clients that already hold a lease, some near misses
                if (leased.size() != 0 && sel < 15) begin
                    len = leased[$urandom_range(0, leased.size() - 1)];
                    mac = lease_mac[len];
                    if ($urandom_range(0, 1) == 1) req_ip = lease_ip[len];
                    if (sel == 0) mac = mac ^ (48'h1 << $urandom_range(0, 47));
                end
                sel = $urandom_range(0, 19);
                if (sel < 8) msg_type = MSG_DISCOVER;
                else if (sel < 17) msg_type = MSG_REQUEST;
                else msg_type = 2'($urandom_range(2, 3));
                send_msg(mk_msg($urandom_range(0, 15) != 0, msg_type, mac,
                                1'($urandom_range(0, 1)), req_ip));
                if ($urandom_range(0, 59) == 0) drain_results();
            end
        end
        snd_no_idle = 1'b0;
        rcv_no_idle = 1'b0;
    endtask

    task automatic test_table_full();
        int n_used;
        int known;
        write_regs(32'h0A00_0000, 32'hFF00_0000);
        known = -1;
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            n_used = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (lease_used[i]) n_used++;
            end
            if (n_used < TABLE_ENTRIES) send_msg(mk_msg(1'b1, MSG_DISCOVER, rand_mac(), 1'b0, '0));
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (lease_used[i]) known = i;
        end
        send_msg(mk_msg(1'b1, MSG_DISCOVER, rand_mac(), 1'b0, '0));
        send_msg(mk_msg(1'b1, MSG_REQUEST, rand_mac(), 1'b1, $urandom));
        if (known >= 0) begin
            send_msg(mk_msg(1'b1, MSG_REQUEST, lease_mac[known], 1'b1, lease_ip[known]));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && o_m_tvalid && m_ready) begin
            reply_cnt++;
            kind_seen[o_m_tuser]++;
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected reply", '0, 64'({o_m_tuser, o_m_tdata}));
            end else begin
                exp_r = pending_replies.pop_front();
                if (o_m_tuser !== exp_r.kind)
                    report_mismatch("reply_kind", 64'(exp_r.kind), 64'(o_m_tuser));
                if (o_m_tdata !== exp_r.ip)
                    report_mismatch("your_ip", 64'(exp_r.ip), 64'(o_m_tdata));
            end
        end
    end

    // reply side draws a random stall, possibly none, before every word unless rcv_no_idle is set
    initial begin
        int gap;
        while (!rst_n) @(posedge clk);
        forever begin
            gap = rcv_no_idle ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (!o_m_tvalid) @(posedge clk);
        end
    end

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            lease_used[i] = 1'b0;
            lease_mac[i]  = '0;
            lease_ip[i]   = '0;
        end
        for (int k = 0; k < 4; k++) kind_seen[k] = 0;
        lease_offset = 32'd1;
        srv_ip       = SERVER_IP_RST;
        net_mask     = MASK_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_and_type();
        test_lease_basic();
        test_pool_exhausted();
        test_random_phases();
        test_table_full();
        drain_results();

        $display("ran %0d messages under %0d register settings, %0d replies checked",
                 msg_cnt, cfg_writes, reply_cnt);
        $display("replies: %0d drop, %0d offer, %0d ack, %0d nak, %0d mismatches",
                 kind_seen[KIND_DROP], kind_seen[KIND_OFFER], kind_seen[KIND_ACK],
                 kind_seen[KIND_NAK], mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dlta_pkg.sv
sv/dlta_cell.sv
sv/dhcp_lease_table_allocator.sv
sim/dhcp_lease_table_allocator_tb.sv
